@@ rtl/core/gtf_pkg.sv @@
// ----------------------------------------------------------------------------
// gtf_pkg
// Shared sizes, types and codes of the grouped team queue.
// ----------------------------------------------------------------------------
`default_nettype none

package gtf_pkg;

  localparam int ELEMENTS = 1024;
  localparam int TEAMS    = 256;

  localparam int ELEM_W = $clog2(ELEMENTS);
  localparam int TEAM_W = (TEAMS > 1) ? $clog2(TEAMS) : 1;
  // team table entry: valid bit above the team number
  localparam int TOFE_W = TEAM_W + 1;

  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [TEAM_W-1:0] team_t;

  localparam logic [1:0] MODE_ASSIGN  = 2'd0;
  localparam logic [1:0] MODE_ENQUEUE = 2'd1;
  localparam logic [1:0] MODE_DEQUEUE = 2'd2;
  localparam logic [1:0] MODE_CLEAR   = 2'd3;

endpackage

`default_nettype wire

@@ rtl/core/grouped_team_fifo_unit.sv @@
// ----------------------------------------------------------------------------
// grouped_team_fifo_unit
// Team queue: elements join behind the last queued member of their team.
// ----------------------------------------------------------------------------
// One item is handled at a time; in_ready is high only while the unit is
// idle. An assign, or a dequeue of an empty queue, is done on acceptance.
// An enqueue passes ENQ_TEAM and ENQ_LAST; one behind a team member adds
// ENQ_LINK and ENQ_FIX (two writes to the single write port of the link
// RAM). A dequeue passes DEQ_TEAM and DEQ_LAST, waiting there for the
// output register to drain. These follow from the chain of registered RAM
// reads: element-to-team table, then last-member table, then link table.
// After reset, and after every clear item, the element-to-team table is
// swept back to "unassigned", one entry a cycle, while no item is accepted.
// Team last-member entries carry flip-flop valid bits and clear at once.
`default_nettype none

module grouped_team_fifo_unit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           mode,
  input  wire logic [9:0]           element,
  input  wire logic [7:0]           team,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [9:0]                dequeued_element
);

  import gtf_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_CLEAR    = 8'b0000_0010,
    S_ENQ_TEAM = 8'b0000_0100,
    S_ENQ_LAST = 8'b0000_1000,
    S_ENQ_LINK = 8'b0001_0000,
    S_ENQ_FIX  = 8'b0010_0000,
    S_DEQ_TEAM = 8'b0100_0000,
    S_DEQ_LAST = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  elem_t             head, tail, elem_r, last_r, clr_cnt;
  logic              nonempty, has_team_r;
  team_t             team_r;
  logic [TEAMS-1:0]  lastv;
  elem_t             out_data;

  // RAM ports
  logic              tofe_we;
  elem_t             tofe_waddr, tofe_raddr;
  logic [TOFE_W-1:0] tofe_wdata, tofe_rdata;
  logic              link_we;
  elem_t             link_waddr, link_wdata, link_raddr, link_rdata;
  logic              last_we;
  team_t             last_waddr, last_raddr;
  elem_t             last_wdata, last_rdata;

  logic  accept, elem_ok, team_ok, out_load, tail_join;
  elem_t in_elem;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_elem  = element[ELEM_W-1:0];
  assign elem_ok  = (32'(element) < 32'(ELEMENTS));
  assign team_ok  = (32'(team) < 32'(TEAMS));

  assign out_load  = (state == S_DEQ_LAST) && (!out_valid || out_ready);
  assign tail_join = !has_team_r || !lastv[team_r] || (last_rdata == tail);

  gtf_ram #(.WIDTH(TOFE_W), .DEPTH(ELEMENTS)) u_tofe_ram (
    .clk   (clk),
    .we    (tofe_we),
    .waddr (tofe_waddr),
    .wdata (tofe_wdata),
    .raddr (tofe_raddr),
    .rdata (tofe_rdata)
  );

  gtf_ram #(.WIDTH(ELEM_W), .DEPTH(ELEMENTS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  gtf_ram #(.WIDTH(ELEM_W), .DEPTH(TEAMS)) u_last_ram (
    .clk   (clk),
    .we    (last_we),
    .waddr (last_waddr),
    .wdata (last_wdata),
    .raddr (last_raddr),
    .rdata (last_rdata)
  );

  // element-to-team table: assign writes, clear sweep
  always_comb begin
    // held on the item's element while busy, so the team and last-member
    // reads stay put through an output stall
    tofe_raddr = (state == S_IDLE) ? ((mode == MODE_ENQUEUE) ? in_elem : head) : elem_r;
    if (state == S_CLEAR) begin
      tofe_we    = 1'b1;
      tofe_waddr = clr_cnt;
      tofe_wdata = '0;
    end else begin
      tofe_we    = accept && (mode == MODE_ASSIGN) && elem_ok;
      tofe_waddr = in_elem;
      tofe_wdata = team_ok ? {1'b1, team[TEAM_W-1:0]} : '0;
    end
  end

  // link table
  always_comb begin
    link_raddr = (state == S_IDLE) ? head : last_rdata;
    link_we    = 1'b0;
    link_waddr = tail;
    link_wdata = elem_r;
    case (state)
      S_ENQ_LAST: begin
        link_we = nonempty && tail_join;
      end
      S_ENQ_LINK: begin
        link_we    = 1'b1;
        link_waddr = elem_r;
        link_wdata = link_rdata;
      end
      S_ENQ_FIX: begin
        link_we    = 1'b1;
        link_waddr = last_r;
      end
      default: begin
        link_we = 1'b0;
      end
    endcase
  end

  // last-member table
  assign last_raddr = tofe_rdata[TEAM_W-1:0];
  assign last_we    = (state == S_ENQ_LAST) && has_team_r;
  assign last_waddr = team_r;
  assign last_wdata = elem_r;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_ENQUEUE: state_next = elem_ok ? S_ENQ_TEAM : S_IDLE;
            MODE_DEQUEUE: state_next = nonempty ? S_DEQ_TEAM : S_IDLE;
            MODE_CLEAR:   state_next = S_CLEAR;
            default:      state_next = S_IDLE;
          endcase
        end
      end
      S_CLEAR:    state_next = (32'(clr_cnt) == ELEMENTS - 1) ? S_IDLE : S_CLEAR;
      S_ENQ_TEAM: state_next = S_ENQ_LAST;
      S_ENQ_LAST: state_next = (!nonempty || tail_join) ? S_IDLE : S_ENQ_LINK;
      S_ENQ_LINK: state_next = S_ENQ_FIX;
      S_ENQ_FIX:  state_next = S_IDLE;
      S_DEQ_TEAM: state_next = S_DEQ_LAST;
      S_DEQ_LAST: state_next = out_load ? S_IDLE : S_DEQ_LAST;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      head      <= '0;
      tail      <= '0;
      nonempty  <= 1'b0;
      lastv     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept && (mode == MODE_CLEAR)) begin
            clr_cnt  <= '0;
            head     <= '0;
            tail     <= '0;
            nonempty <= 1'b0;
            lastv    <= '0;
          end
        end
        S_ENQ_LAST: begin
          if (!nonempty) begin
            head     <= elem_r;
            tail     <= elem_r;
            nonempty <= 1'b1;
          end else if (tail_join) begin
            tail <= elem_r;
          end
          if (has_team_r) begin
            lastv[team_r] <= 1'b1;
          end
        end
        S_DEQ_TEAM: begin
          // link_rdata holds the successor of the head
          if (elem_r == tail) begin
            nonempty <= 1'b0;
          end else begin
            head <= link_rdata;
          end
        end
        S_DEQ_LAST: begin
          if (out_load && has_team_r && lastv[team_r] && (last_rdata == elem_r)) begin
            lastv[team_r] <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      elem_r <= (mode == MODE_DEQUEUE) ? head : in_elem;
    end
    if (state == S_ENQ_TEAM || state == S_DEQ_TEAM) begin
      has_team_r <= tofe_rdata[TEAM_W];
      team_r     <= tofe_rdata[TEAM_W-1:0];
    end
    if (state == S_ENQ_LAST) begin
      last_r <= last_rdata;
    end
    if (out_load) begin
      out_data <= elem_r;
    end
  end

  assign dequeued_element = out_data;

endmodule

`default_nettype wire

@@ rtl/core/gtf_ram.sv @@
// ----------------------------------------------------------------------------
// gtf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gtf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ bench/grouped_team_fifo_unit_test.sv @@
// ----------------------------------------------------------------------------
// grouped_team_fifo_unit_test
// Self-checking bench for the team queue unit.
// ----------------------------------------------------------------------------
// Items go in through random bursts and gaps. Results leave against a receiver
// that stalls on changing patterns. A behavioral copy of the queue, with its
// own team and link tables, predicts every dequeued element, and results are
// checked in order. Directed items come first, then team-heavy traffic, reuse
// noise and long lines that fill and drain.
// ----------------------------------------------------------------------------
module grouped_team_fifo_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gtf_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;  // covers the element-to-team table sweep
  localparam int SETTLE_CYCLES  = 12;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [1:0] mode      = MODE_ASSIGN;
  elem_t      element   = '0;
  team_t      team      = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  elem_t      dequeued_element;

  grouped_team_fifo_unit dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .mode             (mode),
    .element          (element),
    .team             (team),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .dequeued_element (dequeued_element)
  );

  always #2 clk = ~clk;

  // predicted queue state
  team_t       team_of     [ELEMENTS];
  bit          has_team    [ELEMENTS];
  elem_t       link_of     [ELEMENTS];
  bit          link_known  [ELEMENTS];
  bit          queued      [ELEMENTS];
  elem_t       last_member [TEAMS];
  bit          last_known  [TEAMS];
  elem_t       head_elem;
  elem_t       tail_elem;
  bit          line_busy;
  elem_t       due_elements [$];

  int unsigned mode_count [4];
  int unsigned items_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned error_count     = 0;
  int unsigned burst_left      = 0;
  int unsigned idle_cycles     = 0;
  int unsigned stall_left      = 0;
  logic [15:0] stall_pattern   = '1;

  task automatic forget_teams();
    foreach (team_of[i]) begin
      team_of[i]  = '0;
      has_team[i] = 1'b0;
      queued[i]   = 1'b0;
    end
    foreach (last_known[i]) last_known[i] = 1'b0;
    head_elem = '0;
    tail_elem = '0;
    line_busy = 1'b0;
  endtask

  // Link entries never written must not be read; such items are not sent.
  function automatic bit reads_unset_link(logic [1:0] m, elem_t e);
    team_t tm;
    tm = team_of[e];
    if (!line_busy) return 1'b0;
    if (m == MODE_DEQUEUE) return (head_elem != tail_elem) && !link_known[head_elem];
    if (m == MODE_ENQUEUE && has_team[e] && last_known[tm] && last_member[tm] != tail_elem)
      return !link_known[last_member[tm]];
    return 1'b0;
  endfunction

  task automatic team_queue_step(input logic [1:0] m, input elem_t e, input team_t t);
    team_t tm;
    elem_t h;
    elem_t lst;
    case (m)
      MODE_ASSIGN: begin
        team_of[e]  = t;
        has_team[e] = 1'b1;
      end
      MODE_ENQUEUE: begin
        tm = team_of[e];
        if (!line_busy) begin
          head_elem = e;
          tail_elem = e;
          line_busy = 1'b1;
        end else if (!has_team[e] || !last_known[tm] || last_member[tm] == tail_elem) begin
          link_of[tail_elem]    = e;
          link_known[tail_elem] = 1'b1;
          tail_elem             = e;
        end else begin
          lst             = last_member[tm];
          link_of[e]      = link_of[lst];
          link_known[e]   = 1'b1;
          link_of[lst]    = e;
          link_known[lst] = 1'b1;
        end
        if (has_team[e]) begin
          last_member[tm] = e;
          last_known[tm]  = 1'b1;
        end
        queued[e] = 1'b1;
      end
      MODE_DEQUEUE: begin
        if (line_busy) begin
          h = head_elem;
          due_elements.push_back(h);
          queued[h] = 1'b0;
          tm = team_of[h];
          if (has_team[h] && last_known[tm] && last_member[tm] == h) last_known[tm] = 1'b0;
          if (h == tail_elem) line_busy = 1'b0;
          else head_elem = link_of[h];
        end
      end
      MODE_CLEAR: forget_teams();
    endcase
  endtask

  task automatic send_item(input logic [1:0] m, input elem_t e, input team_t t);
    int unsigned gap;
    if (reads_unset_link(m, e)) return;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = (gap == 0) ? $urandom_range(20, 80) : $urandom_range(1, 40);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    mode     <= m;
    element  <= e;
    team     <= t;
    do @(posedge clk); while (!in_ready);
    team_queue_step(m, e, t);
    mode_count[m]++;
    items_sent++;
    burst_left--;
  endtask

  task automatic wait_all_dequeued();
    in_valid <= 1'b0;
    while (due_elements.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input elem_t got, input elem_t want);
    error_count++;
    if (error_count <= 20)
      $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  function automatic elem_t free_element();
    elem_t e;
    e = '0;
    for (int i = 0; i < 8; i++) begin
      e = ($urandom_range(0, 3) == 0) ? elem_t'($urandom) : elem_t'($urandom_range(0, 63));
      if (!queued[e]) return e;
    end
    return e;
  endfunction

  // a few busy teams, now and then any team
  function automatic team_t pick_team();
    return ($urandom_range(0, 4) == 0) ? team_t'($urandom) : team_t'($urandom_range(0, 5));
  endfunction

  task automatic test_directed();
    send_item(MODE_ASSIGN,  10'd0,    8'd0);
    send_item(MODE_ASSIGN,  10'd1023, 8'd255);
    send_item(MODE_ASSIGN,  10'd5,    8'd0);
    send_item(MODE_ASSIGN,  10'd6,    8'd255);
    send_item(MODE_ENQUEUE, 10'd0,    8'd255);  // first item into an empty queue
    send_item(MODE_ENQUEUE, 10'd1023, 8'd0);
    send_item(MODE_ENQUEUE, 10'd7,    8'd255);  // no team: goes to the tail
    send_item(MODE_ENQUEUE, 10'd5,    8'd0);    // behind element 0
    send_item(MODE_ENQUEUE, 10'd6,    8'd0);    // behind element 1023
    send_item(MODE_DEQUEUE, 10'd1023, 8'd255);
    send_item(MODE_ASSIGN,  10'd7,    8'd0);    // queued element changes team
    send_item(MODE_ENQUEUE, 10'd6,    8'd0);    // element already queued
    send_item(MODE_DEQUEUE, 10'd0,    8'd0);
    send_item(MODE_CLEAR,   10'd1023, 8'd255);
    send_item(MODE_DEQUEUE, 10'd0,    8'd0);    // empty queue: no result
    send_item(MODE_ASSIGN,  10'd2,    8'd1);
    send_item(MODE_ENQUEUE, 10'd2,    8'd0);
    send_item(MODE_ASSIGN,  10'd2,    8'd3);    // team 1 keeps a stale last member
    send_item(MODE_ENQUEUE, 10'd3,    8'd0);
    send_item(MODE_DEQUEUE, 10'd0,    8'd0);
    send_item(MODE_DEQUEUE, 10'd0,    8'd0);
    send_item(MODE_ASSIGN,  10'd4,    8'd1);
    send_item(MODE_ENQUEUE, 10'd4,    8'd0);    // empty queue, team entry still valid
    send_item(MODE_DEQUEUE, 10'd0,    8'd0);
    send_item(MODE_DEQUEUE, 10'd0,    8'd0);
  endtask

  task automatic test_team_traffic(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 38)
        send_item(MODE_ENQUEUE, free_element(), team_t'($urandom));
      else if (pick < 56)
        send_item(MODE_ASSIGN, free_element(), pick_team());
      else if (pick < 93)
        send_item(MODE_DEQUEUE, elem_t'($urandom), team_t'($urandom));
      else if (pick < 94)
        send_item(MODE_CLEAR, elem_t'($urandom), team_t'($urandom));
      else
        send_item(2'($urandom), elem_t'($urandom), team_t'($urandom));
    end
  endtask

  // small element set: duplicates, reassigned and self-linked entries
  task automatic test_reuse_noise(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    logic [1:0]  m;
    elem_t       e;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      m = (pick < 30) ? MODE_ENQUEUE : (pick < 60) ? MODE_DEQUEUE :
          (pick < 97) ? MODE_ASSIGN : MODE_CLEAR;
      e = ($urandom_range(0, 1) == 0) ? elem_t'($urandom_range(0, 15)) : elem_t'($urandom);
      send_item(m, e, pick_team());
    end
  endtask

  task automatic test_long_line(input int unsigned rounds);
    repeat (rounds) begin
      repeat (60) begin
        if ($urandom_range(0, 2) == 0) send_item(MODE_ASSIGN, free_element(), pick_team());
        else send_item(MODE_ENQUEUE, free_element(), team_t'($urandom));
      end
      repeat (100) begin
        if (line_busy) send_item(MODE_DEQUEUE, elem_t'($urandom), team_t'($urandom));
      end
      send_item(MODE_CLEAR, elem_t'($urandom), team_t'($urandom));
    end
  endtask

  // receiver: ready pattern rotates and is replaced now and then
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(32, 200);
      case ($urandom_range(0, 3))
        0:       stall_pattern = '1;
        1:       stall_pattern = 16'h8000 >> $urandom_range(0, 15);
        default: stall_pattern = 16'($urandom) | 16'h0001;
      endcase
    end
    stall_left--;
    stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
    out_ready <= stall_pattern[0];
  end

  // result check and watchdog
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (out_valid && out_ready) begin
        results_checked++;
        if (due_elements.size() == 0)
          report_mismatch("dequeued element with none due", dequeued_element, '0);
        else if (dequeued_element !== due_elements[0])
          report_mismatch("dequeued_element", dequeued_element, due_elements.pop_front());
        else
          void'(due_elements.pop_front());
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    forget_teams();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    wait_all_dequeued();
    test_team_traffic(1200);
    wait_all_dequeued();
    test_reuse_noise(450);
    wait_all_dequeued();
    test_long_line(3);
    wait_all_dequeued();
    $display("Sent %0d items: %0d assigns, %0d enqueues, %0d dequeues, %0d clears",
             items_sent, mode_count[MODE_ASSIGN], mode_count[MODE_ENQUEUE],
             mode_count[MODE_DEQUEUE], mode_count[MODE_CLEAR]);
    $display("Checked %0d dequeued elements in order, %0d mismatches",
             results_checked, error_count);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
